// ----- rtl/elgamal_encrypt_decrypt_defines.svh -----
// ----------------------------------------------------------------------------
// ElGamal engine assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ELGAMAL_ENCRYPT_DECRYPT_DEFINES_SVH
`define ELGAMAL_ENCRYPT_DECRYPT_DEFINES_SVH

// same-cycle implication
`define ELG_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("elgamal: same-cycle check failed");

// next-cycle implication
`define ELG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("elgamal: next-cycle check failed");

`endif

// ----- rtl/elg_pkg.sv -----
// ----------------------------------------------------------------------------
// ElGamal engine package
// Sequencer states, multiply kinds, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package elg_pkg;

	localparam int DEFAULT_WIDTH = 32;

	localparam int RESET_MODULUS   = 23;
	localparam int RESET_GENERATOR = 5;
	localparam int RESET_PRIVATE   = 6;
	localparam int RESET_PUBLIC    = 8;

	// configuration register indexes
	localparam logic [1:0] REG_MODULUS   = 2'd0;
	localparam logic [1:0] REG_GENERATOR = 2'd1;
	localparam logic [1:0] REG_PRIVATE   = 2'd2;
	localparam logic [1:0] REG_PUBLIC    = 2'd3;

	// input operation codes
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RED_MSG,
		S_RED_BASE,
		S_POW_CHK,
		S_MUL,
		S_EU_CHK,
		S_EU_DIV,
		S_DONE
	} state_t;

	// what a finished modular product is used for
	typedef enum logic [1:0] {
		MK_ACC,
		MK_SQR,
		MK_FIN
	} mul_kind_t;

endpackage

`default_nettype wire

// ----- rtl/elgamal_encrypt_decrypt.sv -----
// ----------------------------------------------------------------------------
// ElGamal encrypt / decrypt engine
// Bit-serial modular exponentiation, inversion and multiplication mod p.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
//  in      | in        | in_valid/in_stall  | operation, message, nonce, ciphers
//  out     | out       | out_valid/out_stall| result_first, result_second, no_inverse
//
//  One item at a time. Modular products run in the shared shift-and-add
//  unit; an exponent of n bits takes up to 2n products.
//  Encrypt: reductions + two exponentiations + one product.
//  Decrypt: reductions, one exponentiation, then Euclid steps, then one product.
//  Reset restores the register defaults; output stalls hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module elgamal_encrypt_decrypt #(
	parameter int WIDTH = elg_pkg::DEFAULT_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [WIDTH-1:0] cfg_data,
	// input items
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             operation,
	input  wire logic [WIDTH-1:0] message,
	input  wire logic [WIDTH-1:0] nonce,
	input  wire logic [WIDTH-1:0] first_cipher,
	input  wire logic [WIDTH-1:0] second_cipher,
	// results
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [WIDTH-1:0]      result_first,
	output logic [WIDTH-1:0]      result_second,
	output logic                  no_inverse
);

	`include "elgamal_encrypt_decrypt_defines.svh"

	localparam int CW = $clog2(WIDTH + 1);

	elg_pkg::state_t    state_q, state_d;
	elg_pkg::mul_kind_t kind_q;

	// configuration registers
	logic [WIDTH-1:0] p_q, g_q, x_q, y_q;

	// item registers
	logic             op_q, pass_q, flag_q;
	logic [WIDTH-1:0] c1_q, k_q, msg_q, src_q, red_q;
	logic [WIDTH-1:0] base_q, acc_q, exp_q, res1_q;
	logic [WIDTH-1:0] res_first_q, res_second_q;

	// shared shift-and-add unit
	logic [WIDTH-1:0] mul_a_q, mul_b_q, prod_q;
	logic             ph_q, qbit_q;
	logic [CW-1:0]    cnt_q;

	// Euclid registers
	logic [WIDTH-1:0] r0_q, r1_q, t0_q, t1_q, rem_q, div_q;

	// output register
	logic             out_valid_q, no_inverse_q;
	logic [WIDTH-1:0] result_first_q, result_second_q;

	logic in_take, out_load;

	// doubling and addition mod p
	logic [WIDTH:0]   dbl_sum, add_sum, red_sh, rem_sh;
	logic [WIDTH-1:0] dbl_mod, add_mod, red_nx, rem_nx;
	logic             rem_ge;

	assign dbl_sum = {1'b0, prod_q} + {1'b0, prod_q};
	assign dbl_mod = (dbl_sum >= {1'b0, p_q}) ? WIDTH'(dbl_sum - {1'b0, p_q})
		: dbl_sum[WIDTH-1:0];
	assign add_sum = {1'b0, prod_q} + {1'b0, mul_a_q};
	assign add_mod = (add_sum >= {1'b0, p_q}) ? WIDTH'(add_sum - {1'b0, p_q})
		: add_sum[WIDTH-1:0];

	// one bit of a reduction mod p
	assign red_sh = {red_q, src_q[WIDTH-1]};
	assign red_nx = (red_sh >= {1'b0, p_q}) ? WIDTH'(red_sh - {1'b0, p_q})
		: red_sh[WIDTH-1:0];

	// one bit of a restoring division by r1
	assign rem_sh = {rem_q, div_q[WIDTH-1]};
	assign rem_ge = (rem_sh >= {1'b0, r1_q});
	assign rem_nx = rem_ge ? WIDTH'(rem_sh - {1'b0, r1_q}) : rem_sh[WIDTH-1:0];

	// handshake outputs
	always_comb begin
		in_stall  = (state_q != elg_pkg::S_IDLE);
		in_take   = in_valid && !in_stall;
		out_load  = (state_q == elg_pkg::S_DONE) && (!out_valid_q || !out_stall);
		cfg_ready = 1'b1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			elg_pkg::S_IDLE: begin
				if (in_take)
					state_d = (p_q < WIDTH'(2)) ? elg_pkg::S_DONE : elg_pkg::S_RED_MSG;
			end
			elg_pkg::S_RED_MSG: begin
				if (cnt_q == '0)
					state_d = elg_pkg::S_RED_BASE;
			end
			elg_pkg::S_RED_BASE: begin
				if (cnt_q == '0)
					state_d = elg_pkg::S_POW_CHK;
			end
			elg_pkg::S_POW_CHK: begin
				if (exp_q != '0)
					state_d = elg_pkg::S_MUL;
				else if (op_q == elg_pkg::OP_ENCRYPT)
					state_d = pass_q ? elg_pkg::S_MUL : elg_pkg::S_RED_BASE;
				else
					state_d = (acc_q == '0) ? elg_pkg::S_MUL : elg_pkg::S_EU_CHK;
			end
			elg_pkg::S_MUL: begin
				if (cnt_q == '0) begin
					unique case (kind_q)
						elg_pkg::MK_ACC: state_d = elg_pkg::S_MUL;
						elg_pkg::MK_SQR: state_d = elg_pkg::S_POW_CHK;
						default:         state_d = elg_pkg::S_DONE;
					endcase
				end
			end
			elg_pkg::S_EU_CHK: begin
				state_d = (r1_q == '0) ? elg_pkg::S_MUL : elg_pkg::S_EU_DIV;
			end
			elg_pkg::S_EU_DIV: begin
				if (cnt_q == '0)
					state_d = elg_pkg::S_EU_CHK;
			end
			elg_pkg::S_DONE: begin
				if (out_load)
					state_d = elg_pkg::S_IDLE;
			end
			default: state_d = elg_pkg::S_IDLE;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= elg_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			p_q         <= WIDTH'(elg_pkg::RESET_MODULUS);
			g_q         <= WIDTH'(elg_pkg::RESET_GENERATOR);
			x_q         <= WIDTH'(elg_pkg::RESET_PRIVATE);
			y_q         <= WIDTH'(elg_pkg::RESET_PUBLIC);
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			// register writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					elg_pkg::REG_MODULUS:   p_q <= cfg_data;
					elg_pkg::REG_GENERATOR: g_q <= cfg_data;
					elg_pkg::REG_PRIVATE:   x_q <= cfg_data;
					default:                y_q <= cfg_data;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			elg_pkg::S_IDLE: begin
				if (in_take) begin
					op_q         <= operation;
					src_q        <= operation ? second_cipher : message;
					c1_q         <= first_cipher;
					k_q          <= operation ? x_q : nonce;
					pass_q       <= 1'b0;
					flag_q       <= 1'b0;
					red_q        <= '0;
					cnt_q        <= CW'(WIDTH);
					res_first_q  <= '0;
					res_second_q <= '0;
				end
			end
			elg_pkg::S_RED_MSG: begin
				if (cnt_q != '0) begin
					red_q <= red_nx;
					src_q <= src_q << 1;
					cnt_q <= cnt_q - CW'(1);
				end else begin
					msg_q <= red_q;
					src_q <= op_q ? c1_q : g_q;
					red_q <= '0;
					cnt_q <= CW'(WIDTH);
				end
			end
			elg_pkg::S_RED_BASE: begin
				if (cnt_q != '0) begin
					red_q <= red_nx;
					src_q <= src_q << 1;
					cnt_q <= cnt_q - CW'(1);
				end else begin
					base_q <= red_q;
					acc_q  <= WIDTH'(1);
					exp_q  <= k_q;
				end
			end
			elg_pkg::S_POW_CHK: begin
				prod_q <= '0;
				ph_q   <= 1'b0;
				cnt_q  <= CW'(WIDTH);
				if (exp_q != '0) begin
					mul_a_q <= base_q;
					mul_b_q <= exp_q[0] ? acc_q : base_q;
					kind_q  <= exp_q[0] ? elg_pkg::MK_ACC : elg_pkg::MK_SQR;
				end else if (op_q == elg_pkg::OP_ENCRYPT) begin
					if (!pass_q) begin
						res1_q <= acc_q;
						pass_q <= 1'b1;
						src_q  <= y_q;
						red_q  <= '0;
					end else begin
						mul_a_q <= msg_q;
						mul_b_q <= acc_q;
						kind_q  <= elg_pkg::MK_FIN;
					end
				end else if (acc_q == '0) begin
					// zero secret: take the inverse as one
					flag_q  <= 1'b1;
					mul_a_q <= msg_q;
					mul_b_q <= WIDTH'(1);
					kind_q  <= elg_pkg::MK_FIN;
				end else begin
					r0_q <= p_q;
					r1_q <= acc_q;
					t0_q <= '0;
					t1_q <= WIDTH'(1);
				end
			end
			elg_pkg::S_MUL: begin
				if (cnt_q != '0) begin
					if (!ph_q) begin
						prod_q <= dbl_mod;
						ph_q   <= 1'b1;
					end else begin
						if (mul_b_q[WIDTH-1])
							prod_q <= add_mod;
						mul_b_q <= mul_b_q << 1;
						cnt_q   <= cnt_q - CW'(1);
						ph_q    <= 1'b0;
					end
				end else begin
					unique case (kind_q)
						elg_pkg::MK_ACC: begin
							acc_q   <= prod_q;
							mul_a_q <= base_q;
							mul_b_q <= base_q;
							prod_q  <= '0;
							cnt_q   <= CW'(WIDTH);
							kind_q  <= elg_pkg::MK_SQR;
						end
						elg_pkg::MK_SQR: begin
							base_q <= prod_q;
							exp_q  <= exp_q >> 1;
						end
						default: begin
							if (op_q == elg_pkg::OP_ENCRYPT) begin
								res_first_q  <= res1_q;
								res_second_q <= prod_q;
							end else begin
								res_first_q  <= prod_q;
								res_second_q <= '0;
							end
						end
					endcase
				end
			end
			elg_pkg::S_EU_CHK: begin
				prod_q <= '0;
				ph_q   <= 1'b0;
				cnt_q  <= CW'(WIDTH);
				if (r1_q == '0) begin
					// gcd other than one: no inverse
					if (r0_q != WIDTH'(1))
						flag_q <= 1'b1;
					mul_a_q <= msg_q;
					mul_b_q <= (r0_q != WIDTH'(1)) ? WIDTH'(1) : t0_q;
					kind_q  <= elg_pkg::MK_FIN;
				end else begin
					rem_q   <= '0;
					div_q   <= r0_q;
					mul_a_q <= t1_q;
				end
			end
			elg_pkg::S_EU_DIV: begin
				// quotient bits build q*t1 mod p as they appear
				if (cnt_q != '0) begin
					if (!ph_q) begin
						rem_q  <= rem_nx;
						qbit_q <= rem_ge;
						prod_q <= dbl_mod;
						ph_q   <= 1'b1;
					end else begin
						if (qbit_q)
							prod_q <= add_mod;
						div_q <= div_q << 1;
						cnt_q <= cnt_q - CW'(1);
						ph_q  <= 1'b0;
					end
				end else begin
					// t1 = t0 - q*t1 mod p, kept below p
					t1_q <= (t0_q >= prod_q) ? t0_q - prod_q : t0_q + (p_q - prod_q);
					t0_q <= t1_q;
					r0_q <= r1_q;
					r1_q <= rem_q;
				end
			end
			default: begin
			end
		endcase

		if (out_load) begin
			result_first_q  <= res_first_q;
			result_second_q <= res_second_q;
			no_inverse_q    <= flag_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_first  = result_first_q;
	assign result_second = result_second_q;
	assign no_inverse    = no_inverse_q;

	// checks
	`ELG_ASSERT_NEXT(a_take_leaves_idle, in_take, state_q != elg_pkg::S_IDLE)
	`ELG_ASSERT_IMPL(a_prod_reduced, state_q == elg_pkg::S_MUL, prod_q < p_q)
	`ELG_ASSERT_IMPL(a_rem_below_div, state_q == elg_pkg::S_EU_DIV, rem_q < r1_q)
	`ELG_ASSERT_IMPL(a_red_reduced,
		state_q == elg_pkg::S_RED_MSG || state_q == elg_pkg::S_RED_BASE, red_q < p_q)

endmodule

`default_nettype wire

// ----- sim/tb_elgamal_encrypt_decrypt.sv -----
// ----------------------------------------------------------------------------
// ElGamal engine testbench
// Drives encrypt and decrypt transfers under several group settings, with
// random gaps on both channels, and checks every result against typed rows or a
// bit-exact shift-and-add model of modular exponentiation and Euclid inversion.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_elgamal_encrypt_decrypt;

	localparam int WD_LIMIT = 60000;

	typedef struct {
		logic [31:0] first;
		logic [31:0] second;
		logic        flag;
	} cipher_out_t;

	typedef struct {
		logic        op;
		logic [31:0] msg;
		logic [31:0] k;
		logic [31:0] c1;
		logic [31:0] c2;
		bit          typed;
		cipher_out_t res;
	} vec_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [31:0] message;
	logic [31:0] nonce;
	logic [31:0] first_cipher;
	logic [31:0] second_cipher;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result_first;
	logic [31:0] result_second;
	logic        no_inverse;

	elgamal_encrypt_decrypt dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.message(message), .nonce(nonce),
		.first_cipher(first_cipher), .second_cipher(second_cipher),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_first(result_first), .result_second(result_second),
		.no_inverse(no_inverse)
	);

	// local copy of the group registers
	logic [31:0] grp_p = 32'(elg_pkg::RESET_MODULUS);
	logic [31:0] grp_g = 32'(elg_pkg::RESET_GENERATOR);
	logic [31:0] grp_x = 32'(elg_pkg::RESET_PRIVATE);
	logic [31:0] grp_y = 32'(elg_pkg::RESET_PUBLIC);

	cipher_out_t pending_results[$];
	int errors = 0;
	int idle_cycles = 0;
	bit calm = 0;
	int recv_hold = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 0;
	end

	// --- modular arithmetic, shift-and-add like the hardware ---
	function automatic logic [63:0] add_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [63:0] s;
		s = a + b;
		if (s < a || s >= m)
			s = s - m;
		return s;
	endfunction

	function automatic logic [63:0] mul_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [63:0] acc;
		acc = 0;
		for (int i = 63; i >= 0; i--) begin
			acc = add_m(acc, acc, m);
			if (b[i])
				acc = add_m(acc, a, m);
		end
		return acc;
	endfunction

	function automatic logic [63:0] exp_m(logic [63:0] base, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		acc = 1;
		base = base % m;
		while (e != 0) begin
			if (e[0])
				acc = mul_m(acc, base, m);
			base = mul_m(base, base, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	// Euclid inverse; returns 1 when s shares a factor with m
	function automatic bit inv_m(logic [63:0] s, logic [63:0] m, output logic [63:0] inv);
		logic [63:0] r0, r1, r2, t0, t1, t2, q, prod;
		r0 = m; r1 = s; t0 = 0; t1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			r2 = r0 - q * r1;
			prod = mul_m(q % m, t1, m);
			t2 = (t0 >= prod) ? t0 - prod : t0 + (m - prod);
			r0 = r1; r1 = r2; t0 = t1; t1 = t2;
		end
		inv = t0;
		return r0 != 1;
	endfunction

	function automatic cipher_out_t elgamal_result(logic op, logic [31:0] msg, logic [31:0] k,
			logic [31:0] c1, logic [31:0] c2);
		cipher_out_t r;
		logic [63:0] p, s, inv;
		r = '{0, 0, 0};
		p = 64'(grp_p);
		if (p >= 2) begin
			if (op == elg_pkg::OP_ENCRYPT) begin
				r.first  = 32'(exp_m(64'(grp_g), 64'(k), p));
				r.second = 32'(mul_m(64'(msg) % p, exp_m(64'(grp_y), 64'(k), p), p));
			end else begin
				s = exp_m(64'(c1), 64'(grp_x), p);
				inv = 1;
				if (s == 0 || inv_m(s, p, inv)) begin
					inv = 1;
					r.flag = 1;
				end
				r.first = 32'(mul_m(64'(c2) % p, inv, p));
			end
		end
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(20, 150);
	endfunction

	// --- result check, receiver stalls, watchdog ---
	always @(posedge clk) begin
		cipher_out_t e;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WD_LIMIT) begin
				$display("tb_elgamal_encrypt_decrypt: FAIL");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result %h %h %b", $time,
						result_first, result_second, no_inverse);
					errors++;
				end else begin
					e = pending_results.pop_front();
					if (result_first !== e.first) begin
						$display("%0t: result_first exp %h got %h", $time, e.first, result_first);
						errors++;
					end
					if (result_second !== e.second) begin
						$display("%0t: result_second exp %h got %h", $time, e.second,
							result_second);
						errors++;
					end
					if (no_inverse !== e.flag) begin
						$display("%0t: no_inverse exp %b got %b", $time, e.flag, no_inverse);
						errors++;
					end
				end
			end
			// receiver stall runs
			if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				out_stall <= 1'b1;
			end else begin
				recv_hold <= gap_len();
				out_stall <= 1'b0;
			end
		end
	end

	// one input transfer; valid stays high until the next item or a gap
	task automatic send_item(logic op, logic [31:0] msg, logic [31:0] k, logic [31:0] c1,
			logic [31:0] c2, bit typed, cipher_out_t res);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation <= op;
		message <= msg;
		nonce <= k;
		first_cipher <= c1;
		second_cipher <= c2;
		in_valid <= 1'b1;
		pending_results.push_back(typed ? res : elgamal_result(op, msg, k, c1, c2));
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// registers are only written with the engine idle
	task automatic set_group(logic [31:0] p, logic [31:0] g, logic [31:0] x, logic [31:0] y);
		logic [31:0] vals[4];
		logic [1:0] idx[4];
		vals = '{p, g, x, y};
		idx = '{elg_pkg::REG_MODULUS, elg_pkg::REG_GENERATOR, elg_pkg::REG_PRIVATE,
			elg_pkg::REG_PUBLIC};
		in_valid <= 1'b0;
		drain();
		repeat (4) @(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (cfg_ready !== 1'b1);
		end
		cfg_valid <= 1'b0;
		grp_p = p; grp_g = g; grp_x = x; grp_y = y;
	endtask

	// random items: encrypts, decrypts of real ciphertexts, zero secrets, noise
	task automatic random_items(int count, bit pause_once);
		int kind;
		logic [31:0] msg, k, c1, c2;
		cipher_out_t enc, none;
		none = '{0, 0, 0};
		for (int i = 0; i < count; i++) begin
			if (pause_once && i == count / 2) begin
				in_valid <= 1'b0;
				drain();
				@(posedge clk);
			end
			kind = $urandom_range(0, 9);
			msg = $urandom();
			if (kind[0] && grp_p >= 2)
				msg = msg % grp_p;
			k = kind[1] ? $urandom() : $urandom_range(0, 1000);
			c1 = $urandom();
			c2 = $urandom();
			if (kind <= 3) begin
				send_item(elg_pkg::OP_ENCRYPT, msg, k, c1, c2, 0, none);
			end else if (kind <= 6) begin
				enc = elgamal_result(elg_pkg::OP_ENCRYPT, msg, k, 0, 0);
				send_item(elg_pkg::OP_DECRYPT, msg, k, enc.first, enc.second, 0, none);
			end else if (kind == 7) begin
				send_item(elg_pkg::OP_DECRYPT, msg, k, 32'(grp_p * $urandom_range(0, 2)), c2,
					0, none);
			end else begin
				send_item(elg_pkg::OP_DECRYPT, msg, k, c1, c2, 0, none);
			end
		end
	endtask

	vec_t dir_vecs[12] = '{
		'{elg_pkg::OP_ENCRYPT, 32'd7,        32'd0,        32'd0,        32'd0,        1,
			'{1, 7, 0}},
		'{elg_pkg::OP_ENCRYPT, 32'hFFFFFFFF, 32'd0,        32'd0,        32'd0,        1,
			'{1, 11, 0}},
		'{elg_pkg::OP_DECRYPT, 32'd0,        32'd0,        32'd0,        32'd30,       1,
			'{7, 0, 1}},
		'{elg_pkg::OP_DECRYPT, 32'd0,        32'd0,        32'd23,       32'hFFFFFFFF, 1,
			'{11, 0, 1}},
		'{elg_pkg::OP_ENCRYPT, 32'd22,       32'd1,        32'd0,        32'd0,        1,
			'{5, 15, 0}},
		'{elg_pkg::OP_ENCRYPT, 32'd0,        32'hFFFFFFFF, 32'd0,        32'd0,        0,
			'{0, 0, 0}},
		'{elg_pkg::OP_DECRYPT, 32'd0,        32'd0,        32'hFFFFFFFF, 32'd0,        0,
			'{0, 0, 0}},
		'{elg_pkg::OP_DECRYPT, 32'd0,        32'd0,        32'd5,        32'd15,       0,
			'{0, 0, 0}},
		'{elg_pkg::OP_ENCRYPT, 32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFF, 32'hFFFFFFFF, 0,
			'{0, 0, 0}},
		'{elg_pkg::OP_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555, 0,
			'{0, 0, 0}},
		'{elg_pkg::OP_DECRYPT, 32'd0,        32'd0,        32'd1,        32'd22,       0,
			'{0, 0, 0}},
		'{elg_pkg::OP_ENCRYPT, 32'hAAAAAAAA, 32'h55555555, 32'd0,        32'd0,        0,
			'{0, 0, 0}}
	};

	initial begin
		logic [31:0] x;
		clk = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = elg_pkg::REG_MODULUS;
		cfg_data = 0;
		in_valid = 0;
		operation = elg_pkg::OP_ENCRYPT;
		message = 0;
		nonce = 0;
		first_cipher = 0;
		second_cipher = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under the reset group
		foreach (dir_vecs[i])
			send_item(dir_vecs[i].op, dir_vecs[i].msg, dir_vecs[i].k, dir_vecs[i].c1,
				dir_vecs[i].c2, dir_vecs[i].typed, dir_vecs[i].res);
		random_items(8, 1);

		// largest 32-bit prime, consistent key pair
		x = $urandom();
		set_group(32'hFFFFFFFB, 32'd2, x, 32'(exp_m(64'd2, 64'(x), 64'hFFFFFFFB)));
		random_items(20, 1);

		// all-ones generator and private key, no idling
		calm = 1;
		set_group(32'hFFFFFFFB, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'(exp_m(64'hFFFFFFFF, 64'hFFFFFFFF, 64'hFFFFFFFB)));
		random_items(14, 0);
		calm = 0;

		// modulus three, zero private key
		set_group(32'd3, 32'd2, 32'd0, 32'd1);
		random_items(14, 0);

		// composite modulus: secrets sharing a factor with it
		set_group(32'd15, 32'd7, 32'd3, 32'd13);
		send_item(elg_pkg::OP_DECRYPT, 0, 0, 32'd3, 32'd14, 0, '{0, 0, 0});
		send_item(elg_pkg::OP_DECRYPT, 0, 0, 32'd5, 32'd9, 0, '{0, 0, 0});
		random_items(14, 0);

		// modulus below two gives all-zero results
		set_group(32'd1, 32'hFFFFFFFF, $urandom(), $urandom());
		send_item(elg_pkg::OP_DECRYPT, 0, 0, 32'd0, 32'd5, 1, '{0, 0, 0});
		send_item(elg_pkg::OP_ENCRYPT, 32'd9, 32'd3, 0, 0, 1, '{0, 0, 0});
		random_items(6, 0);

		// all-ones composite modulus
		x = $urandom();
		set_group(32'hFFFFFFFF, 32'd3, x, 32'(exp_m(64'd3, 64'(x), 64'hFFFFFFFF)));
		random_items(20, 1);

		in_valid <= 1'b0;
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb_elgamal_encrypt_decrypt: PASS");
		else
			$display("tb_elgamal_encrypt_decrypt: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
